FILE: sv/vjb_pkg.sv
// shared types, constants and helpers for the voice jitter buffer
// no dependencies; imported by vjb_ctrl, vjb_dpath and voice_jitter_buffer_top
package vjb_pkg;

    // default geometry
    localparam int unsigned VJB_SLOTS      = 8;
    localparam int unsigned VJB_SLOT_WORDS = 32;

    // fixed field widths
    localparam int unsigned FRAME_W = 32;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned TDATA_W = 112;
    localparam int unsigned LIMIT_W = 8;

    localparam logic [LIMIT_W-1:0] EMPTY_LIMIT_RST = 8'd100;

    // command codes carried on tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_GET    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_COPY,
        ST_COMMIT,
        ST_EMPTY,
        ST_EMIT_RD,
        ST_EMIT_LD
    } vjb_state_t;

    // controller to datapath
    typedef struct packed {
        logic ins_accept;
        logic scan_start;
        logic scan_lowest;
        logic scan_step;
        logic copy_step;
        logic commit;
        logic empty_get;
        logic emit_rd;
        logic emit_ld;
        logic empty_ld;
    } vjb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ready;
        logic scan_last;
        logic scan_is_lowest;
        logic any_found;
        logic copy_done;
        logic emit_last;
        logic out_free;
    } vjb_sts_t;

    // keep the lowest nbytes bytes of a word
    function automatic logic [DATA_W-1:0] byte_mask(input logic [2:0] nbytes);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < int'(nbytes))
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: sv/vjb_ctrl.sv
// sequencing state machine of the voice jitter buffer
// depends on vjb_pkg; drives commands into vjb_dpath
module vjb_ctrl
    import vjb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    input  logic       s_tlast,
    input  vjb_sts_t   sts,
    output vjb_cmd_t   cmd
);

    vjb_state_t state_reg;
    vjb_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_INSERT)
                    begin
                        if (s_tlast)
                        begin
                            state_next = sts.ready ? ST_SCAN : ST_COPY;
                        end
                    end
                    else
                    begin
                        state_next = sts.ready ? ST_SCAN : ST_EMPTY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.scan_is_lowest)
                begin
                    state_next = ST_COPY;
                end
                else if (sts.any_found)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_EMPTY;
                end
            end
            ST_COPY:
            begin
                if (sts.copy_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_INSERT)
                    begin
                        cmd.ins_accept = 1'b1;
                        if (s_tlast && sts.ready)
                        begin
                            cmd.scan_start  = 1'b1;
                            cmd.scan_lowest = 1'b1;
                        end
                    end
                    else if (sts.ready)
                    begin
                        cmd.scan_start = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.empty_get = !sts.scan_is_lowest && !sts.any_found;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            ST_EMPTY:
            begin
                cmd.empty_ld = sts.out_free;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_ld = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/vjb_dpath.sv
// datapath of the voice jitter buffer: staging and slot memories, slot table,
// sequential minimum search, copy engine and output register; depends on vjb_pkg
module vjb_dpath
    import vjb_pkg::*;
#(
    parameter int unsigned SLOTS      = VJB_SLOTS,
    parameter int unsigned SLOT_WORDS = VJB_SLOT_WORDS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vjb_cmd_t             cmd,
    output vjb_sts_t             sts,
    input  logic [FRAME_W-1:0]   in_frame,
    input  logic [LEN_W-1:0]     in_len,
    input  logic [DATA_W-1:0]    in_data,
    input  logic                 in_last,
    input  logic                 cfg_we,
    input  logic [LIMIT_W-1:0]   cfg_data,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int unsigned SIW       = $clog2(SLOTS);
    localparam int unsigned WIW       = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int unsigned CW        = $clog2(SLOT_WORDS + 1);
    localparam int unsigned FW        = $clog2(SLOTS + 1);
    localparam int unsigned MAX_BYTES = SLOT_WORDS * 8;
    localparam int unsigned MEM_DEPTH = SLOTS << WIW;

    // memories
    logic [DATA_W-1:0]  stage_mem [SLOT_WORDS];
    logic [DATA_W-1:0]  slot_mem  [MEM_DEPTH];
    logic [DATA_W-1:0]  stage_rd_reg;
    logic [DATA_W-1:0]  slot_rd_reg;

    // slot table
    logic [FRAME_W-1:0] frame_reg [SLOTS];
    logic [LEN_W-1:0]   len_reg   [SLOTS];
    logic [CW-1:0]      wcnt_reg  [SLOTS];

    logic [CW-1:0]      stage_cnt_reg;
    logic [FW-1:0]      fill_reg;
    logic               ready_reg;
    logic [LIMIT_W-1:0] empty_gets_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [FRAME_W-1:0] new_frame_reg;
    logic [LEN_W-1:0]   new_len_reg;
    logic [SIW-1:0]     sel_reg;
    logic [SIW-1:0]     scan_idx_reg;
    logic               any_reg;
    logic               lowest_reg;
    logic [FRAME_W-1:0] best_frame_reg;
    logic [CW-1:0]      copy_idx_reg;
    logic               pend_reg;
    logic [WIW-1:0]     waddr_reg;
    logic [CW-1:0]      word_idx_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_last_reg;

    logic [LEN_W-1:0]   len_sat;
    logic [SIW-1:0]     fill_slot;
    logic [FW-1:0]      fill_inc;
    logic [LIMIT_W-1:0] empty_inc;
    logic [FRAME_W-1:0] scan_frame;
    logic               scan_take;
    logic [LEN_W-1:0]   cur_len;
    logic [9:0]         base10;
    logic [9:0]         rem10;
    logic [9:0]         words10;
    logic               emit_last;
    logic [DATA_W-1:0]  emit_word;
    logic               out_free;

    // length saturation and fill slot choice
    always_comb
    begin
        len_sat   = ({1'b0, in_len} > 10'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : in_len;
        fill_slot = (fill_reg < FW'(SLOTS)) ? fill_reg[SIW-1:0] : SIW'(SLOTS - 1);
        fill_inc  = fill_reg + 1'b1;
        empty_inc = empty_gets_reg + 1'b1;
    end

    // search candidate
    always_comb
    begin
        scan_frame = frame_reg[scan_idx_reg];
        scan_take  = (lowest_reg || scan_frame != '0)
                   && (!any_reg || scan_frame < best_frame_reg);
    end

    // word masking for emit
    always_comb
    begin
        cur_len   = len_reg[sel_reg];
        base10    = 10'(word_idx_reg) << 3;
        rem10     = {1'b0, cur_len} - base10;
        words10   = ({1'b0, cur_len} + 10'd7) >> 3;
        if (words10 == '0)
        begin
            words10 = 10'd1;
        end
        emit_last = (10'(word_idx_reg) + 10'd1) == words10;
        if (cur_len == '0 || word_idx_reg >= wcnt_reg[sel_reg]
            || {1'b0, cur_len} <= base10)
        begin
            emit_word = '0;
        end
        else if (rem10 < 10'd8)
        begin
            emit_word = slot_rd_reg & byte_mask(rem10[2:0]);
        end
        else
        begin
            emit_word = slot_rd_reg;
        end
        out_free  = !out_valid_reg || m_tready;
    end

    // staging memory
    always_ff @(posedge clk)
    begin
        if (cmd.ins_accept && stage_cnt_reg < CW'(SLOT_WORDS))
        begin
            stage_mem[stage_cnt_reg[WIW-1:0]] <= in_data;
        end
        if (cmd.copy_step && copy_idx_reg < stage_cnt_reg)
        begin
            stage_rd_reg <= stage_mem[copy_idx_reg[WIW-1:0]];
        end
    end

    // slot payload memory
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            slot_mem[{sel_reg, waddr_reg}] <= stage_rd_reg;
        end
        if (cmd.emit_rd)
        begin
            slot_rd_reg <= slot_mem[{sel_reg, word_idx_reg[WIW-1:0]}];
        end
    end

    // copy engine and staging count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_cnt_reg <= '0;
            copy_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            waddr_reg     <= '0;
        end
        else
        begin
            pend_reg <= 1'b0;
            if (cmd.ins_accept && stage_cnt_reg < CW'(SLOT_WORDS))
            begin
                stage_cnt_reg <= stage_cnt_reg + 1'b1;
            end
            if (cmd.copy_step && copy_idx_reg < stage_cnt_reg)
            begin
                pend_reg     <= 1'b1;
                waddr_reg    <= copy_idx_reg[WIW-1:0];
                copy_idx_reg <= copy_idx_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                stage_cnt_reg <= '0;
                copy_idx_reg  <= '0;
            end
        end
    end

    // slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                frame_reg[i] <= '0;
                len_reg[i]   <= '0;
                wcnt_reg[i]  <= '0;
            end
        end
        else if (cmd.commit)
        begin
            frame_reg[sel_reg] <= new_frame_reg;
            len_reg[sel_reg]   <= new_len_reg;
            wcnt_reg[sel_reg]  <= stage_cnt_reg;
        end
        else if (cmd.emit_ld && emit_last)
        begin
            frame_reg[sel_reg] <= '0;
        end
    end

    // fill phase, readiness, empty get counter and limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            ready_reg      <= 1'b0;
            empty_gets_reg <= '0;
            limit_reg      <= EMPTY_LIMIT_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.ins_accept && in_last && !ready_reg)
            begin
                fill_reg <= fill_inc;
                if (fill_inc >= FW'(SLOTS))
                begin
                    ready_reg <= 1'b1;
                end
            end
            else if (cmd.empty_get)
            begin
                if (empty_inc > limit_reg)
                begin
                    fill_reg       <= '0;
                    ready_reg      <= 1'b0;
                    empty_gets_reg <= '0;
                end
                else
                begin
                    empty_gets_reg <= empty_inc;
                end
            end
        end
    end

    // packet header latch, slot selection and sequential search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg        <= '0;
            scan_idx_reg   <= '0;
            any_reg        <= 1'b0;
            lowest_reg     <= 1'b0;
            best_frame_reg <= '0;
            word_idx_reg   <= '0;
            new_frame_reg  <= '0;
            new_len_reg    <= '0;
        end
        else
        begin
            if (cmd.ins_accept && in_last)
            begin
                new_frame_reg <= in_frame;
                new_len_reg   <= len_sat;
                if (!ready_reg)
                begin
                    sel_reg <= fill_slot;
                end
            end
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                any_reg      <= 1'b0;
                lowest_reg   <= cmd.scan_lowest;
                word_idx_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_take)
                begin
                    sel_reg        <= scan_idx_reg;
                    best_frame_reg <= scan_frame;
                    any_reg        <= 1'b1;
                end
            end
            if (cmd.emit_ld)
            begin
                word_idx_reg <= word_idx_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ld || cmd.empty_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            out_found_reg <= 1'b1;
            out_frame_reg <= frame_reg[sel_reg];
            out_len_reg   <= cur_len;
            out_data_reg  <= emit_word;
            out_last_reg  <= emit_last;
        end
        else if (cmd.empty_ld)
        begin
            out_found_reg <= 1'b0;
            out_frame_reg <= '0;
            out_len_reg   <= '0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0, out_data_reg, out_len_reg, out_frame_reg};

    // status
    always_comb
    begin
        sts.ready          = ready_reg;
        sts.scan_last      = scan_idx_reg == SIW'(SLOTS - 1);
        sts.scan_is_lowest = lowest_reg;
        sts.any_found      = any_reg;
        sts.copy_done      = (copy_idx_reg == stage_cnt_reg) && !pend_reg;
        sts.emit_last      = emit_last;
        sts.out_free       = out_free;
    end

endmodule

FILE: sv/voice_jitter_buffer_top.sv
// voice jitter buffer: an insert word is staged while idle; a last word that commits is copied
// from staging to slot memory and then committed, after a lowest-frame search once ready
// get: a lowest-frame search, then a slot memory read and an output load per word (slot memory port);
// a not-ready get answers with a miss; one item is worked on at a time
// rst_n clears control state and the slot table; payload memories are not cleared
module voice_jitter_buffer_top
    import vjb_pkg::*;
#(
    parameter int unsigned SLOTS      = VJB_SLOTS,
    parameter int unsigned SLOT_WORDS = VJB_SLOT_WORDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // frame, byte count, data word
    input  logic               s_tuser,   // cmd
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // result frame, byte count, data word
    output logic               m_tuser,   // found
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    vjb_cmd_t cmd;
    vjb_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    vjb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and search
    vjb_dpath #(
        .SLOTS      (SLOTS),
        .SLOT_WORDS (SLOT_WORDS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_frame (s_tdata[31:0]),
        .in_len   (s_tdata[40:32]),
        .in_data  (s_tdata[104:41]),
        .in_last  (s_tlast),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a miss is always a single zero transfer
    a_miss_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0)
        else $error("miss result not a single zero transfer");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_ld || cmd.empty_ld) |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // a commit returns the block to accepting input
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> s_tready)
        else $error("block not idle after commit");

endmodule

FILE: dv/voice_jitter_buffer_top_tb.sv
// testbench for the voice jitter buffer: random and directed insert/get traffic
// with an item-level predictor of the slot table; depends on vjb_pkg and the top
`timescale 1ns / 100ps

module voice_jitter_buffer_top_tb;
    import vjb_pkg::*;

    localparam int unsigned NSLOT = VJB_SLOTS;
    localparam int unsigned NWORD = VJB_SLOT_WORDS;
    localparam int unsigned MAXB  = NWORD * 8;
    localparam int unsigned LIMIT_CYC = 4000000;

    typedef struct packed {
        logic                cmd;
        logic                last;
        logic [FRAME_W-1:0]  frame;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
    } jb_item_t;

    typedef struct packed {
        logic                found;
        logic                last;
        logic [FRAME_W-1:0]  frame;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   data;
    } jb_word_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    // transfer seen at the last rising edge
    logic               s_tready_q;

    // predictor state
    logic [DATA_W-1:0]  pay_mem [NSLOT][NWORD];
    logic [FRAME_W-1:0] frame_tab [NSLOT];
    logic [LEN_W-1:0]   len_tab [NSLOT];
    logic [DATA_W-1:0]  stage_mem [NWORD];
    int unsigned        stage_cnt;
    int unsigned        fill_idx;
    bit                 buf_ready;
    logic [7:0]         empty_cnt;
    logic [7:0]         empty_lim;

    jb_item_t pending_items [$];
    jb_word_t expected_words [$];
    int unsigned mismatches;
    int unsigned cycles;
    bit          no_idle;

    voice_jitter_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor: applies one accepted item and queues the words it yields
    task automatic jb_apply(input jb_item_t it);
        int unsigned slot;
        int unsigned ln;
        int unsigned nw;
        int unsigned valid;
        bit          any;
        jb_word_t    w;
        logic [DATA_W-1:0] d;
        if (it.cmd == CMD_INSERT)
        begin
            if (stage_cnt < NWORD)
            begin
                stage_mem[stage_cnt] = it.data;
                stage_cnt++;
            end
            if (!it.last)
                return;
            ln = (it.len > MAXB) ? MAXB : it.len;
            if (!buf_ready)
            begin
                slot = (fill_idx < NSLOT) ? fill_idx : NSLOT - 1;
                fill_idx++;
                if (fill_idx >= NSLOT)
                    buf_ready = 1'b1;
            end
            else
            begin
                slot = 0;
                for (int i = 1; i < NSLOT; i++)
                    if (frame_tab[i] < frame_tab[slot])
                        slot = i;
            end
            for (int i = 0; i < NWORD; i++)
                pay_mem[slot][i] = (i < stage_cnt) ? stage_mem[i] : '0;
            frame_tab[slot] = it.frame;
            len_tab[slot] = LEN_W'(ln);
            stage_cnt = 0;
            return;
        end
        w = '0;
        w.last = 1'b1;
        if (!buf_ready)
        begin
            expected_words.push_back(w);
            return;
        end
        any = 1'b0;
        slot = 0;
        for (int i = 0; i < NSLOT; i++)
            if (frame_tab[i] != 0 && (!any || frame_tab[i] < frame_tab[slot]))
            begin
                slot = i;
                any = 1'b1;
            end
        if (!any)
        begin
            empty_cnt = empty_cnt + 8'd1;
            if (empty_cnt > empty_lim)
            begin
                fill_idx = 0;
                buf_ready = 1'b0;
                empty_cnt = '0;
            end
            expected_words.push_back(w);
            return;
        end
        ln = len_tab[slot];
        nw = (ln + 7) / 8;
        if (nw == 0)
            nw = 1;
        for (int k = 0; k < nw; k++)
        begin
            d = (ln == 0) ? '0 : pay_mem[slot][k];
            valid = (ln > k * 8) ? ln - k * 8 : 0;
            if (valid < 8)
                d &= (64'd1 << (valid * 8)) - 64'd1;
            w.found = 1'b1;
            w.frame = frame_tab[slot];
            w.len = LEN_W'(ln);
            w.data = d;
            w.last = (k + 1 == nw);
            expected_words.push_back(w);
        end
        frame_tab[slot] = '0;
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready_q)
            begin
                if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 27))
                begin
                    jb_item_t it;
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.cmd;
                    s_tlast  <= it.last;
                    s_tdata  <= TDATA_W'({it.data, it.len, it.frame});
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
        s_tready_q <= s_tvalid && s_tready;

    // input monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            jb_item_t it;
            it.cmd   = s_tuser;
            it.last  = s_tlast;
            it.frame = s_tdata[FRAME_W-1:0];
            it.len   = s_tdata[FRAME_W +: LEN_W];
            it.data  = s_tdata[FRAME_W+LEN_W +: DATA_W];
            jb_apply(it);
        end
    end

    // output monitor and compare
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            jb_word_t got;
            jb_word_t exp_w;
            got.found = m_tuser;
            got.last  = m_tlast;
            got.frame = m_tdata[FRAME_W-1:0];
            got.len   = m_tdata[FRAME_W +: LEN_W];
            got.data  = m_tdata[FRAME_W+LEN_W +: DATA_W];
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %p", got);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_w, got);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYC)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic jb_item_t mk_word(input logic [DATA_W-1:0] d);
        jb_item_t it;
        it = '0;
        it.cmd = CMD_INSERT;
        it.data = d;
        return it;
    endfunction

    function automatic logic [DATA_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // one packet of nw words closed by a last word
    task automatic add_packet(input int unsigned nw, input logic [FRAME_W-1:0] fr,
                              input logic [LEN_W-1:0] ln);
        jb_item_t it;
        for (int i = 0; i < nw; i++)
        begin
            it = mk_word(rnd64());
            if (i == nw - 1)
            begin
                it.last = 1'b1;
                it.frame = fr;
                it.len = ln;
            end
            it.frame = (i == nw - 1) ? fr : $urandom;
            it.len = (i == nw - 1) ? ln : LEN_W'($urandom_range(511));
            pending_items.push_back(it);
        end
    endtask

    task automatic add_get();
        jb_item_t it;
        it = '0;
        it.cmd = CMD_GET;
        it.last = 1'($urandom_range(1));
        it.frame = $urandom;
        it.len = LEN_W'($urandom_range(511));
        it.data = rnd64();
        pending_items.push_back(it);
    endtask

    // wait until all items went in and every word came out, then a drain pause
    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        empty_lim = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned ln;
        int unsigned nw;
        repeat (n)
        begin
            if ($urandom_range(99) < 55)
            begin
                ln = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(40);
                nw = ($urandom_range(19) == 0) ? $urandom_range(40, 33) :
                     (ln + 7) / 8 + ($urandom_range(3) == 0 ? $urandom_range(2) : 0);
                if (nw == 0)
                    nw = 1;
                add_packet(nw, ($urandom_range(15) == 0) ? 32'd0 :
                           ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom_range(60),
                           LEN_W'(ln));
            end
            else
            begin
                add_get();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        no_idle = 1'b0;
        stage_cnt = 0;
        fill_idx = 0;
        buf_ready = 1'b0;
        empty_cnt = '0;
        empty_lim = EMPTY_LIMIT_RST;
        for (int i = 0; i < NSLOT; i++)
        begin
            frame_tab[i] = '0;
            len_tab[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: get before ready, fill, extremes, empty gets
        add_get();
        add_packet(1, 32'hFFFF_FFFF, 9'd8);
        add_packet(1, 32'd0, 9'd0);
        add_packet(2, 32'd5, 9'd511);
        add_packet(1, 32'd1, 9'd0);
        add_packet(1, 32'd7, 9'd3);
        add_packet(NWORD + 2, 32'd2, 9'd256);
        add_packet(1, 32'd9, 9'd13);
        add_packet(1, 32'd9, 9'd1);
        add_packet(1, 32'd3, 9'd64);
        repeat (10)
            add_get();
        drain();

        // empty counter wraps back to fill quickly at the low extreme
        write_limit(8'd0);
        random_phase(16);
        drain();
        write_limit(8'd255);
        no_idle = 1'b1;
        random_phase(14);
        drain();
        no_idle = 1'b0;
        write_limit(8'd3);
        random_phase(16);
        drain();
        write_limit(8'd254);
        random_phase(10);
        drain();

        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
